[sv/fllb_pkg.sv]
// shared types and constants of the fill-to-limit load balancer
package fllb_pkg;

   // item kinds carried on req_tuser
   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // configuration register indexes
   localparam logic CSR_PEER_COUNT    = 1'b0;
   localparam logic CSR_INITIAL_LIMIT = 1'b1;

   // fixed field widths
   localparam int PEER_COUNT_BITS = 6;
   localparam int LIMIT_BITS      = 16;
   localparam int PEER_FIELD_BITS = 5;

   // register reset values
   localparam logic [PEER_COUNT_BITS-1:0] RESET_PEER_COUNT    = 6'd32;
   localparam logic [LIMIT_BITS-1:0]      RESET_INITIAL_LIMIT = 16'd100;

   // x / 10 for 16-bit x is (x * 0xCCCD) >> 19
   localparam logic [LIMIT_BITS-1:0] DIV10_MULT  = 16'hCCCD;
   localparam int                    DIV10_SHIFT = 19;

   // command from the sequencer to every cell
   typedef struct packed {
      logic load;    // place the probe at the start index
      logic shift;   // move the probe one cell along
      logic wrap;    // probe passes from the last peer in use back to cell zero
      logic inc;     // probed cell below the limit takes a connection
      logic dec;     // addressed cell gives back a connection
   } cell_cmd_type;

   // status from one cell
   typedef struct packed {
      logic hit;     // probe is here and the count is below the limit
      logic zero;    // this cell is addressed for release and holds zero
   } cell_stat_type;

endpackage

[sv/fill_to_limit_load_balancer.sv]
// Fill-to-limit load balancer: a row of peer cells, each holding one peer's connection
// count, with a probe bit handed from cell to cell one step per cycle under a small
// sequencer. An acquire walks the probe from the cursor over the peers in use and takes
// the first peer below the shared limit; when every peer is full the limit rises by a
// tenth (at least one, saturated at the cap) and a second walk starts from peer zero; if
// the limit is already at its cap the acquire is refused. An acquire's result is loaded
// when the walking probe finds a free peer or ends its last walk. A release passes
// through ST_REL, where its result is loaded. The input is ready again in the cycle
// after a result is loaded, and a result that cannot leave because the previous one
// still waits on the rsp side holds the sequencer until it can.
// One item is worked at a time; a new item may be accepted while the previous result
// still waits on the rsp side.
// Configuration writes are to be made only while no item is in flight; the block does not enforce this.
module fill_to_limit_load_balancer #(
   parameter int MAX_PEERS  = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] release_peer, [7:5] zero
   input  logic        req_tuser,   // [0] opcode
   // result item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [4:0] chosen_peer, [20:5] current_limit,
                                    // [21] limit_raised, [22] refused, [23] release_error
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IW  = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int LB  = fllb_pkg::LIMIT_BITS;
   localparam int PCB = fllb_pkg::PEER_COUNT_BITS;
   localparam int PFB = fllb_pkg::PEER_FIELD_BITS;
   localparam int CAP_INT = (COUNT_BITS >= LB) ? 65535 : ((1 << COUNT_BITS) - 1);
   localparam logic [LB-1:0] LIMIT_CAP = LB'(CAP_INT);
   localparam logic [LB-1:0] RESET_LIMIT =
      (LIMIT_CAP < fllb_pkg::RESET_INITIAL_LIMIT) ? LIMIT_CAP : fllb_pkg::RESET_INITIAL_LIMIT;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REL
   } state_type;

   state_type             state_ff;
   logic [PCB-1:0]        peer_count_ff;
   logic [LB-1:0]         limit_ff;
   logic [IW-1:0]         cursor_ff;
   logic [IW-1:0]         idx_ff;
   logic [IW-1:0]         steps_ff;
   logic                  pass2_ff;
   logic [PFB-1:0]        rp_ff;
   logic                  rsp_valid_ff;
   logic [23:0]           rsp_data_ff;

   fllb_pkg::cell_cmd_type  cmd;
   fllb_pkg::cell_stat_type stat [MAX_PEERS];
   logic [MAX_PEERS-1:0]    probe;
   logic [IW-1:0]           start_idx;
   logic [IW-1:0]           rel_idx;
   logic [IW-1:0]           n_last;
   logic [IW-1:0]           scan_start;
   logic                    any_hit;
   logic                    any_zero;
   logic                    out_free;
   logic                    accept;
   logic                    rp_in_range;
   logic                    last_step;
   logic                    can_raise;
   logic                    rsp_load;
   logic [2*LB-1:0]         div_prod;
   logic [LB-1:0]           raise_step;
   logic [LB:0]             raise_sum;
   logic [LB-1:0]           raised_limit;
   logic [LB-1:0]           csr_limit;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // last index of the peers in use
   always_comb begin
      priority if (peer_count_ff == '0) begin
         n_last = '0;
      end else if (int'(peer_count_ff) > MAX_PEERS) begin
         n_last = IW'(MAX_PEERS - 1);
      end else begin
         n_last = IW'(peer_count_ff - PCB'(1));
      end
   end

   assign scan_start  = (cursor_ff <= n_last) ? cursor_ff : '0;
   assign last_step   = (steps_ff == n_last);
   assign rp_in_range = (int'(rp_ff) < MAX_PEERS);
   assign rel_idx     = IW'(rp_ff);
   assign start_idx   = (state_ff == ST_IDLE) ? scan_start : '0;
   assign can_raise   = (limit_ff < LIMIT_CAP);

   // a result item is loaded this cycle
   assign rsp_load = out_free &
                     (((state_ff == ST_SCAN) &
                       (any_hit | (last_step & (pass2_ff | ~can_raise)))) |
                      (state_ff == ST_REL));

   // limit step: a tenth of the limit, at least one, saturated at the cap
   assign div_prod   = limit_ff * fllb_pkg::DIV10_MULT;
   assign raise_step = (div_prod[2*LB-1:fllb_pkg::DIV10_SHIFT] == '0) ? LB'(1)
                       : LB'(div_prod[2*LB-1:fllb_pkg::DIV10_SHIFT]);
   assign raise_sum  = {1'b0, limit_ff} + {1'b0, raise_step};
   assign raised_limit = (raise_sum > {1'b0, LIMIT_CAP}) ? LIMIT_CAP : raise_sum[LB-1:0];

   // written initial limit, clamped to one .. cap
   assign csr_limit = (csr_wdata == '0) ? LB'(1)
                      : ((csr_wdata > LIMIT_CAP) ? LIMIT_CAP : csr_wdata);

   // combine cell status
   always_comb begin
      any_hit  = 1'b0;
      any_zero = 1'b0;
      for (int i = 0; i < MAX_PEERS; i++) begin
         any_hit  = any_hit | stat[i].hit;
         any_zero = any_zero | stat[i].zero;
      end
   end

   // commands to the cells
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = accept & (req_tuser == fllb_pkg::OP_ACQUIRE);
         end
         ST_SCAN: begin
            if (any_hit) begin
               cmd.inc = out_free;
            end else if (last_step) begin
               cmd.load = ~pass2_ff & can_raise;
            end else begin
               cmd.shift = 1'b1;
               cmd.wrap  = (idx_ff == n_last);
            end
         end
         ST_REL: begin
            cmd.dec = out_free & rp_in_range & ~any_zero;
         end
         default: cmd = '0;
      endcase
   end

   // row of peer cells
   for (genvar g = 0; g < MAX_PEERS; g++) begin : g_cell
      logic prev;
      if (g == 0) begin : g_first
         assign prev = cmd.wrap;
      end else begin : g_next
         assign prev = probe[g-1];
      end
      fllb_cell #(
         .IDX (g),
         .IW  (IW),
         .CB  (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .start_idx  (start_idx),
         .rel_idx    (rel_idx),
         .limit      (limit_ff),
         .probe_prev (prev),
         .probe_out  (probe[g]),
         .stat       (stat[g])
      );
   end

   // sequencer, shared state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         peer_count_ff <= fllb_pkg::RESET_PEER_COUNT;
         limit_ff      <= RESET_LIMIT;
         cursor_ff     <= '0;
         idx_ff        <= '0;
         steps_ff      <= '0;
         pass2_ff      <= 1'b0;
         rp_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_data_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_load | (rsp_valid_ff & ~rsp_tready);

         // configuration writes
         if (csr_we) begin
            unique case (csr_index)
               fllb_pkg::CSR_PEER_COUNT:    peer_count_ff <= csr_wdata[PCB-1:0];
               fllb_pkg::CSR_INITIAL_LIMIT: limit_ff      <= csr_limit;
               default: ;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rp_ff <= req_tdata[PFB-1:0];
                  if (req_tuser == fllb_pkg::OP_ACQUIRE) begin
                     idx_ff   <= scan_start;
                     steps_ff <= '0;
                     pass2_ff <= 1'b0;
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_REL;
                  end
               end
            end
            ST_SCAN: begin
               if (any_hit) begin
                  if (out_free) begin
                     cursor_ff    <= idx_ff;
                     rsp_data_ff  <= {1'b0, 1'b0, pass2_ff, limit_ff, PFB'(idx_ff)};
                     state_ff     <= ST_IDLE;
                  end
               end else if (last_step) begin
                  if (!pass2_ff && can_raise) begin
                     // all full: raise the limit and walk again from peer zero
                     limit_ff  <= raised_limit;
                     cursor_ff <= '0;
                     idx_ff    <= '0;
                     steps_ff  <= '0;
                     pass2_ff  <= 1'b1;
                  end else if (out_free) begin
                     // refused, limit saturated or still full after raising
                     rsp_data_ff  <= {1'b0, 1'b1, pass2_ff, limit_ff, PFB'(0)};
                     state_ff     <= ST_IDLE;
                  end
               end else begin
                  idx_ff   <= (idx_ff == n_last) ? '0 : idx_ff + IW'(1);
                  steps_ff <= steps_ff + IW'(1);
               end
            end
            ST_REL: begin
               if (out_free) begin
                  rsp_data_ff  <= {~rp_in_range | any_zero, 1'b0, 1'b0, limit_ff, PFB'(0)};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[sv/fllb_cell.sv]
// one peer cell: connection count, probe bit and local compare
module fllb_cell #(
   parameter int IDX = 0,
   parameter int IW  = 5,
   parameter int CB  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fllb_pkg::cell_cmd_type      cmd,
   input  logic [IW-1:0]               start_idx,
   input  logic [IW-1:0]               rel_idx,
   input  logic [fllb_pkg::LIMIT_BITS-1:0] limit,
   input  logic                        probe_prev,
   output logic                        probe_out,
   output fllb_pkg::cell_stat_type     stat
);

   localparam int CMPW = (CB > fllb_pkg::LIMIT_BITS) ? CB : fllb_pkg::LIMIT_BITS;

   logic [CB-1:0] count_ff, count_in;
   logic          probe_ff, probe_in;
   logic          below;
   logic          match_rel;

   // local compare against the shared limit
   assign below     = CMPW'(count_ff) < CMPW'(limit);
   assign match_rel = (rel_idx == IW'(IDX));

   assign stat.hit  = probe_ff & below;
   assign stat.zero = match_rel & (count_ff == '0);
   assign probe_out = probe_ff;

   // probe movement along the row
   always_comb begin
      probe_in = probe_ff;
      priority if (cmd.load) begin
         probe_in = (start_idx == IW'(IDX));
      end else if (cmd.shift) begin
         probe_in = probe_prev & ((IDX == 0) | ~cmd.wrap);
      end
   end

   // count update
   always_comb begin
      count_in = count_ff;
      priority if (cmd.inc && probe_ff && below) begin
         count_in = count_ff + CB'(1);
      end else if (cmd.dec && match_rel && (count_ff != '0)) begin
         count_in = count_ff - CB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         probe_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         probe_ff <= probe_in;
      end
   end

endmodule
